FILE: rtl/core/sqpi_pkg.sv
// Package for the shifting character queue with positional insert.
// Holds sizes, operation and status codes, cell commands and payload types.
// No dependencies.
package sqpi_pkg;

   localparam int CAPACITY = 4;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int POS_W    = 3;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_INSERT  = 2'd1;
   localparam logic [1:0] OP_DEQUEUE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_TAKE_LEFT  = 2'd2,
      CELL_TAKE_RIGHT = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count_nxt;
      logic [1:0]       status;
      logic             pop;
   } ctrl_stat_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       char_in;
      logic [POS_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic [7:0] head_char;
      logic [2:0] occupancy;
      logic       is_full;
      logic [1:0] status;
   } rsp_type;

endpackage

FILE: rtl/core/shift_queue_with_position_insert.sv
// Shifting character queue with positional insert: a chain of CAPACITY cells
// that appends, inserts at a 1-based position (0 acts as 1, past the tail
// appends) or removes the front character. Each request transaction yields
// one registered response transaction; a new request is taken every
// cycle as long as the response register is free or being drained, since
// every cell loads, shifts or holds in the same cycle and the fill count is
// updated alongside. A full queue drops the character with status 1; a
// dequeue on an empty queue changes nothing and reports status 2.
// Depends on sqpi_pkg, sqpi_ctrl and sqpi_cell.
module shift_queue_with_position_insert
   import sqpi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                        accept;
   cell_cmd_type [CAPACITY-1:0] cmd;
   ctrl_stat_type               stat;
   logic [7:0]                  cell_q   [CAPACITY];
   logic [7:0]                  cell_nxt [CAPACITY];

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   sqpi_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cmd    (cmd),
      .stat   (stat)
   );

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [7:0] left_char;
      logic [7:0] right_char;

      if (g == 0) begin : g_first
         assign left_char = req_data.char_in;
      end else begin : g_mid
         assign left_char = cell_q[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_char = cell_q[g];
      end else begin : g_inner
         assign right_char = cell_q[g+1];
      end

      sqpi_cell u_cell (
         .clock      (clock),
         .cmd        (cmd[g]),
         .load_char  (req_data.char_in),
         .left_char  (left_char),
         .right_char (right_char),
         .char_q     (cell_q[g]),
         .char_nxt   (cell_nxt[g])
      );
   end

   always_comb begin
      rsp_data_in.char_out  = stat.pop ? cell_q[0] : 8'd0;
      rsp_data_in.head_char = (stat.count_nxt != '0) ? cell_nxt[0] : 8'd0;
      rsp_data_in.occupancy = 3'(stat.count_nxt);
      rsp_data_in.is_full   = (stat.count_nxt == CNT_W'(CAPACITY));
      rsp_data_in.status    = stat.status;
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/sqpi_cell.sv
// One storage cell of the queue chain: holds a character, loads a new one
// or takes the value of its left or right neighbor. Depends on sqpi_pkg.
module sqpi_cell
   import sqpi_pkg::*;
(
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic [7:0]   load_char,
   input  logic [7:0]   left_char,
   input  logic [7:0]   right_char,
   output logic [7:0]   char_q,
   output logic [7:0]   char_nxt
);

   logic [7:0] char_ff;
   logic [7:0] char_in;

   always_comb begin
      unique case (cmd)
         CELL_HOLD:       char_in = char_ff;
         CELL_LOAD:       char_in = load_char;
         CELL_TAKE_LEFT:  char_in = left_char;
         CELL_TAKE_RIGHT: char_in = right_char;
         default:         char_in = char_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign char_q   = char_ff;
   assign char_nxt = char_in;

endmodule

FILE: rtl/core/sqpi_ctrl.sv
// Queue control: keeps the fill count, decodes each transaction and issues
// a command to every cell of the chain. Depends on sqpi_pkg.
module sqpi_ctrl
   import sqpi_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  req_type                       req,
   output cell_cmd_type [CAPACITY-1:0]   cmd,
   output ctrl_stat_type                 stat
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [POS_W-1:0] pos_m1;
   logic [IDX_W-1:0] idx;
   logic             full;
   logic             empty;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);
   assign pos_m1 = (req.position == '0) ? '0 : req.position - POS_W'(1);

   always_comb begin
      if (req.op == OP_ENQUEUE) begin
         idx = IDX_W'(count_ff);
      end else if (CMP_W'(pos_m1) > CMP_W'(count_ff)) begin
         // beyond the tail: append
         idx = IDX_W'(count_ff);
      end else begin
         idx = IDX_W'(pos_m1);
      end
   end

   always_comb begin
      stat.status    = STATUS_OK;
      stat.pop       = 1'b0;
      stat.count_nxt = count_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         cmd[i] = CELL_HOLD;
      end
      priority if (req.op == OP_ENQUEUE || req.op == OP_INSERT) begin
         if (full) begin
            stat.status = STATUS_FULL;
         end else begin
            stat.count_nxt = count_ff + CNT_W'(1);
            // load at idx, push everything behind it one place back
            for (int i = 0; i < CAPACITY; i++) begin
               if (IDX_W'(i) == idx) begin
                  cmd[i] = CELL_LOAD;
               end else if (IDX_W'(i) > idx) begin
                  cmd[i] = CELL_TAKE_LEFT;
               end
            end
         end
      end else if (req.op == OP_DEQUEUE) begin
         if (empty) begin
            stat.status = STATUS_EMPTY;
         end else begin
            stat.pop       = 1'b1;
            stat.count_nxt = count_ff - CNT_W'(1);
            for (int i = 0; i < CAPACITY - 1; i++) begin
               cmd[i] = CELL_TAKE_RIGHT;
            end
         end
      end else begin
         stat.status = STATUS_OK;
      end
      // hold the chain unless a transaction is taken
      if (!accept) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cmd[i] = CELL_HOLD;
         end
      end
   end

   assign count_in = accept ? stat.count_nxt : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
